// ----- src/spns_pkg.sv -----
// shared types and codes for the stroke point store with nearest search
// no dependencies
package spns_pkg;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [4:0]         stroke_id;
        logic [2:0]         segment;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic [7:0]         split_point;
    } t_in_word;

    typedef struct packed {
        logic [8:0] answer;
        logic [1:0] status;
    } t_out_word;

    // result of the distance unit
    typedef struct packed {
        logic        valid;
        logic [32:0] sqd;
    } t_dist_res;

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_NEW       = 3'd1;
    localparam logic [2:0] OP_ADD_POINT = 3'd2;
    localparam logic [2:0] OP_ADD_DIV   = 3'd3;
    localparam logic [2:0] OP_SEG_LEN   = 3'd4;
    localparam logic [2:0] OP_NEAREST   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [8:0] ANSWER_MAX = 9'd511;

endpackage

// ----- src/spns_dist.sv -----
// squared euclidean distance unit, one point per cycle
// depends on spns_pkg
module spns_dist import spns_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_qx,
    input  logic signed [15:0] i_qy,
    input  logic signed [15:0] i_px,
    input  logic signed [15:0] i_py,
    output t_dist_res          o_res
);

    logic signed [16:0] w_dx;
    logic signed [16:0] w_dy;
    logic signed [33:0] w_sqx;
    logic signed [33:0] w_sqy;
    logic [31:0]        r_sqx;
    logic [31:0]        r_sqy;
    logic               r_valid;

    assign w_dx  = {i_qx[15], i_qx} - {i_px[15], i_px};
    assign w_dy  = {i_qy[15], i_qy} - {i_py[15], i_py};
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        // squares never exceed 32 bits
        r_sqx <= w_sqx[31:0];
        r_sqy <= w_sqy[31:0];
    end

    assign o_res.valid = r_valid;
    assign o_res.sqd   = {1'b0, r_sqx} + {1'b0, r_sqy};

endmodule

// ----- src/stroke_point_store_nearest_search_top.sv -----
// nearest scans its range with one point read a cycle from the point memory into
// one shared distance unit; the other opcodes go straight from exec to done
// one word at a time; the next word is taken once the result sits in the output register
// reset: stroke, point and division counts clear at once; no memory clearing pass
// depends on spns_pkg, spns_dist
module stroke_point_store_nearest_search_top import spns_pkg::*; #(
    parameter int MAX_STROKES       = 32,
    parameter int POINTS_PER_STROKE = 256,
    parameter int MAX_DIVISIONS     = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int SW    = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
    localparam int OW    = $clog2(MAX_STROKES + 1);
    localparam int PW    = $clog2(POINTS_PER_STROKE);
    localparam int CW    = $clog2(POINTS_PER_STROKE + 1);
    localparam int DW    = (MAX_DIVISIONS > 1) ? $clog2(MAX_DIVISIONS) : 1;
    localparam int DCW   = $clog2(MAX_DIVISIONS + 1);
    localparam int DEPTH = MAX_STROKES * POINTS_PER_STROKE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = (CW > 9) ? CW : 9;

    typedef enum logic [2:0] {S_IDLE, S_ROW, S_EXEC, S_SCAN, S_DONE} t_state;
    typedef logic [MAX_DIVISIONS-1:0][7:0] t_row;

    t_state          r_state;
    t_in_word        r_in;
    logic [OW-1:0]   r_open;
    logic [CW-1:0]   r_pcnt [MAX_STROKES];
    logic [DCW-1:0]  r_dcnt [MAX_STROKES];
    t_row            mem_div [MAX_STROKES];
    t_row            r_drow;
    logic [15:0]     mem_x [DEPTH];
    logic [15:0]     mem_y [DEPTH];
    logic [15:0]     r_rx;
    logic [15:0]     r_ry;
    logic [LW-1:0]   r_idx;
    logic [LW-1:0]   r_lim;
    logic [AW-1:0]   r_base;
    logic [PW-1:0]   r_best;
    logic [32:0]     r_bestd;
    logic            r_v1;
    logic [PW-1:0]   r_i1;
    logic [PW-1:0]   r_i2;
    t_out_word       r_res;
    t_out_word       r_out;
    logic            r_ovalid;

    logic [SW-1:0]   w_sidx;
    logic            w_present;
    logic [CW-1:0]   w_size;
    logic [DCW-1:0]  w_dn;
    logic [7:0]      w_seg8;
    logic [7:0]      w_dn8;
    logic [7:0]      w_dseg;
    logic [7:0]      w_dprev;
    logic [7:0]      w_dlast;
    logic [LW-1:0]   w_sizel;
    logic [LW-1:0]   w_len;
    logic [LW-1:0]   w_start;
    logic [LW-1:0]   w_limit;
    logic            w_nzero;
    logic [DCW-1:0]  w_pos;
    t_row            w_new_row;
    t_out_word       w_res;
    logic            w_go_scan;
    logic            w_exec;
    logic            w_pt_we;
    logic            w_div_we;
    logic [AW-1:0]   w_base;
    logic [AW-1:0]   w_rd_addr;
    logic            w_issue;
    t_dist_res       w_dres;

    function automatic logic [8:0] f_sat(input logic [LW-1:0] v);
        return (v > LW'(ANSWER_MAX)) ? ANSWER_MAX : v[8:0];
    endfunction

    assign w_exec    = (r_state == S_EXEC);
    assign w_sidx    = SW'(r_in.stroke_id);
    assign w_present = (9'(r_in.stroke_id) < 9'(r_open));
    assign w_size    = r_pcnt[w_sidx];
    assign w_dn      = r_dcnt[w_sidx];
    assign w_seg8    = 8'(r_in.segment);
    assign w_dn8     = 8'(w_dn);
    assign w_dseg    = r_drow[DW'(r_in.segment)];
    assign w_dprev   = r_drow[DW'(r_in.segment - 3'd1)];
    assign w_dlast   = r_drow[DW'(w_dn - DCW'(1))];
    assign w_sizel   = LW'(w_size);
    assign w_base    = AW'(w_sidx) * AW'(POINTS_PER_STROKE);

    // segment length
    always_comb begin
        if (w_dn == '0) begin
            w_len = w_sizel;
        end else if (w_seg8 > w_dn8) begin
            w_len = '0;
        end else if (w_seg8 == w_dn8) begin
            w_len = (w_sizel > LW'(w_dlast)) ? w_sizel - LW'(w_dlast) : '0;
        end else if (w_seg8 == 8'd0) begin
            w_len = LW'(w_dseg);
        end else begin
            w_len = LW'(w_dseg) - LW'(w_dprev);
        end
    end

    // search range
    always_comb begin
        w_nzero = 1'b0;
        w_start = '0;
        w_limit = w_sizel;
        if (!(w_seg8 == 8'd0 && w_dn == '0)) begin
            if (w_seg8 > w_dn8) begin
                w_nzero = 1'b1;
            end
            w_start = (w_seg8 == 8'd0) ? '0 : LW'(w_dprev);
            if (w_seg8 == w_dn8) begin
                w_limit = (w_size == '0) ? '0 : w_sizel - LW'(1);
            end else begin
                w_limit = LW'(w_dseg);
            end
        end
        if (w_limit > w_sizel) begin
            w_limit = w_sizel;
        end
    end

    // sorted insert, after equal entries
    always_comb begin
        w_pos = '0;
        for (int j = 0; j < MAX_DIVISIONS; j++) begin
            if (DCW'(j) < w_dn && r_drow[j] <= r_in.split_point) begin
                w_pos = w_pos + DCW'(1);
            end
        end
        for (int j = 0; j < MAX_DIVISIONS; j++) begin
            if (DCW'(j) < w_pos) begin
                w_new_row[j] = r_drow[j];
            end else if (DCW'(j) == w_pos) begin
                w_new_row[j] = r_in.split_point;
            end else begin
                w_new_row[j] = r_drow[(j > 0) ? j - 1 : 0];
            end
        end
    end

    // per opcode result and side effects
    always_comb begin
        w_res     = '{answer: 9'd0, status: ST_OK};
        w_go_scan = 1'b0;
        w_pt_we   = 1'b0;
        w_div_we  = 1'b0;
        case (r_in.opcode)
            OP_CLEAR: begin
                w_res.status = ST_OK;
            end
            OP_NEW: begin
                if (9'(r_open) >= 9'(MAX_STROKES)) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_res.answer = f_sat(LW'(r_open));
                end
            end
            OP_ADD_POINT, OP_ADD_DIV, OP_SEG_LEN, OP_NEAREST: begin
                if (!w_present) begin
                    w_res.status = ST_ABSENT;
                end else if (r_in.opcode == OP_ADD_POINT) begin
                    if (w_size >= CW'(POINTS_PER_STROKE)) begin
                        w_res.status = ST_FULL;
                    end else begin
                        w_pt_we = w_exec;
                    end
                end else if (r_in.opcode == OP_ADD_DIV) begin
                    if (w_dn >= DCW'(MAX_DIVISIONS)) begin
                        w_res.status = ST_FULL;
                    end else begin
                        w_div_we = w_exec;
                    end
                end else if (r_in.opcode == OP_SEG_LEN) begin
                    w_res.answer = f_sat(w_len);
                end else begin
                    w_go_scan = !w_nzero;
                end
            end
            default: begin
                w_res.status = ST_OK;
            end
        endcase
    end

    assign w_issue   = (r_state == S_SCAN) && (r_idx < r_lim);
    assign w_rd_addr = r_base + AW'(r_idx);

    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            mem_x[w_base + AW'(w_size)] <= r_in.coord_x;
            mem_y[w_base + AW'(w_size)] <= r_in.coord_y;
        end
        r_rx <= mem_x[w_rd_addr];
        r_ry <= mem_y[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_div_we) begin
            mem_div[w_sidx] <= w_new_row;
        end
        r_drow <= mem_div[w_sidx];
    end

    spns_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_qx    (r_in.coord_x),
        .i_qy    (r_in.coord_y),
        .i_px    (r_rx),
        .i_py    (r_ry),
        .o_res   (w_dres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= '0;
            r_ovalid <= 1'b0;
            r_v1     <= 1'b0;
            for (int k = 0; k < MAX_STROKES; k++) begin
                r_pcnt[k] <= '0;
                r_dcnt[k] <= '0;
            end
        end else begin
            // the done state reloads the output register itself
            if (r_ovalid && !i_out_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            r_v1 <= w_issue;
            r_i1 <= PW'(r_idx);
            r_i2 <= r_i1;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_word;
                        r_state <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_res   <= w_res;
                    r_state <= w_go_scan ? S_SCAN : S_DONE;
                    r_idx   <= w_start;
                    r_lim   <= w_limit;
                    r_base  <= w_base;
                    r_best  <= '0;
                    r_bestd <= '1;
                    if (r_in.opcode == OP_CLEAR) begin
                        r_open <= '0;
                        for (int k = 0; k < MAX_STROKES; k++) begin
                            r_pcnt[k] <= '0;
                            r_dcnt[k] <= '0;
                        end
                    end else if (r_in.opcode == OP_NEW && w_res.status == ST_OK) begin
                        r_pcnt[SW'(r_open)] <= '0;
                        r_dcnt[SW'(r_open)] <= '0;
                        r_open <= r_open + OW'(1);
                    end
                    if (w_pt_we) begin
                        r_pcnt[w_sidx] <= w_size + CW'(1);
                    end
                    if (w_div_we) begin
                        r_dcnt[w_sidx] <= w_dn + DCW'(1);
                    end
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + LW'(1);
                    end
                    // first minimum wins
                    if (w_dres.valid && w_dres.sqd < r_bestd) begin
                        r_bestd <= w_dres.sqd;
                        r_best  <= r_i2;
                    end
                    if (!w_issue && !r_v1 && !w_dres.valid) begin
                        r_res.answer <= f_sat(LW'(r_best));
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

endmodule
